### rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg: shared types and constants for the Huffman code bit packer
// Request kinds and stream field layout of the packer unit.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // Request kind carried in tuser on the slave side
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  localparam int unsigned OpW      = 2;
  localparam int unsigned SymbolW  = 8;
  localparam int unsigned CodeBitsW = 32;
  localparam int unsigned CodeLenW = 6;
  localparam int unsigned ByteW    = 8;

  // Slave tdata: symbol, code_bits, code_len packed from bit 0, padded to bytes
  localparam int unsigned InFieldsW = SymbolW + CodeBitsW + CodeLenW;
  localparam int unsigned InTdataW  = ((InFieldsW + 7) / 8) * 8;

  localparam int unsigned SymbolLsb  = 0;
  localparam int unsigned CodeBitsLsb = SymbolLsb + SymbolW;
  localparam int unsigned CodeLenLsb = CodeBitsLsb + CodeBitsW;

endpackage : hcbp_pkg

### rtl/huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit: Huffman encoder bit packer
// Loads a per-symbol code table, appends looked-up codes MSB first into a
// byte accumulator and streams out every completed byte; a flush request
// emits the partial byte zero-padded in its low bits.
// ----------------------------------------------------------------------------
//
//  channel  | dir | fields (low bit up)                          | handshake
//  ---------+-----+----------------------------------------------+-----------
//  s_axis   | in  | tuser: op; tdata: symbol, code_bits, code_len | tvalid/tready
//  m_axis   | out | tdata: out_byte; tlast: last                  | tvalid/tready
//
// A load request writes the code and length memories at the accept edge.
// An encode or flush request passes through the lookup stage (registered
// memory read), then the byte emitter holds it while it yields its bytes,
// at most four for a 32-bit code; the single emitter thus bounds how long
// an encode occupies the unit. The first byte passes the lookup registers,
// the emitter buffer and the output register before it shows on m_axis.
// Requests that yield at most one byte sustain one per cycle while m_axis
// is not stalled. Reset clears the length valid bits, the accumulator
// and all pipeline valids; the code memory holds no reset value.
// A stall on m_axis holds the output register, then the emitter, then the
// lookup stage, and finally drops s_axis_tready_o.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS  = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: [7:0] symbol, [39:8] code_bits, [45:40] code_len, [47:46] zero
  input  logic [hcbp_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // tuser: [1:0] op
  input  logic [hcbp_pkg::OpW-1:0]        s_axis_tuser_i,
  // master side
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata: [7:0] out_byte
  output logic [hcbp_pkg::ByteW-1:0]      m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);

  import hcbp_pkg::*;

  // Longest code the table keeps; codes are stored in that many bits
  localparam int LenBound = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
  localparam int LenW     = $clog2(LenBound + 1);
  localparam int CodeW    = LenBound;
  localparam int SymW     = $clog2(NUM_SYMBOLS);
  // Accumulator word: pending byte plus one code, rounded up to whole bytes
  localparam int NumBytes = (7 + LenBound) / 8 + 1;
  localparam int AccW     = 8 * NumBytes;
  localparam int BufW     = AccW - 8;
  localparam int CntW     = $clog2(NumBytes);
  localparam int ShW      = $clog2(AccW + 1);

  // Unpack the request
  op_e                 in_op;
  logic [SymbolW-1:0]  in_sym;
  logic [CodeBitsW-1:0] in_code;
  logic [CodeLenW-1:0] in_len;
  logic [SymW-1:0]     in_idx;
  logic                in_range;
  logic [LenW-1:0]     load_len;

  assign in_op    = op_e'(s_axis_tuser_i);
  assign in_sym   = s_axis_tdata_i[SymbolLsb +: SymbolW];
  assign in_code  = s_axis_tdata_i[CodeBitsLsb +: CodeBitsW];
  assign in_len   = s_axis_tdata_i[CodeLenLsb +: CodeLenW];
  assign in_idx   = in_sym[SymW-1:0];
  assign in_range = ({1'b0, in_sym} < (SymbolW + 1)'(NUM_SYMBOLS));
  // Saturate oversized lengths to the table bound
  assign load_len = (in_len > CodeLenW'(LenBound)) ? LenW'(LenBound) : LenW'(in_len);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Which requests reach the lookup stage, and which write the table
  logic do_load;
  logic to_s1;
  always_comb begin
    do_load = 1'b0;
    to_s1   = 1'b0;
    unique case (in_op)
      OP_LOAD:   do_load = in_range;
      OP_ENCODE: to_s1   = in_range;
      OP_FLUSH:  to_s1   = 1'b1;
      default: begin
        do_load = 1'b0;
        to_s1   = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Code table: code memory (no reset), length memory with valid bits.
  // Loads write and lookups read at the accept edge, so a lookup right after
  // a load of the same symbol already sees the new entry.
  // --------------------------------------------------------------------------
  logic [CodeW-1:0]       code_mem [NUM_SYMBOLS];
  logic [LenW-1:0]        len_mem  [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] len_vld_q;

  logic [CodeW-1:0] rd_code_q;
  logic [LenW-1:0]  rd_len_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && do_load) begin
      code_mem[in_idx] <= in_code[CodeW-1:0];
      len_mem[in_idx]  <= load_len;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && to_s1) begin
      rd_code_q <= code_mem[in_idx];
      rd_len_q  <= len_mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else if (in_acc) begin
      if (do_load) begin
        len_vld_q[in_idx] <= 1'b1;
      end
      if (to_s1) begin
        rd_vld_q <= len_vld_q[in_idx];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Lookup stage: merge the code into the accumulator
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  op_e  s1_op_q;
  logic s1_adv;

  logic [7:0] pend_q, pend_d;
  logic [2:0] fill_q, fill_d;

  logic [LenW-1:0]               n_len;
  logic [CodeW-1:0]              code_msk;
  logic [ShW-1:0]                sh;
  logic [ShW-1:0]                tot;
  logic [AccW-1:0]               acc_w;
  logic [NumBytes-1:0][7:0]      acc_by;
  logic [CntW-1:0]               enc_cnt;
  logic [CntW-1:0]               ld_cnt;
  logic [BufW-1:0]               ld_buf;

  always_comb begin
    // An entry never loaded has length zero
    n_len    = rd_vld_q ? rd_len_q : '0;
    code_msk = rd_code_q & ~({CodeW{1'b1}} << n_len);
    // Place the code right below the bits already pending
    sh       = ShW'(AccW) - ShW'(fill_q) - ShW'(n_len);
    acc_w    = {pend_q, BufW'(0)} | (AccW'(code_msk) << sh);
    acc_by   = acc_w;
    tot      = ShW'(fill_q) + ShW'(n_len);
    enc_cnt  = CntW'(tot >> 3);

    pend_d = pend_q;
    fill_d = fill_q;
    ld_cnt = '0;
    ld_buf = acc_w[AccW-1:8];
    unique case (s1_op_q)
      OP_ENCODE: begin
        ld_cnt = enc_cnt;
        fill_d = tot[2:0];
        pend_d = acc_by[CntW'(NumBytes - 1) - enc_cnt];
      end
      OP_FLUSH: begin
        ld_cnt = (fill_q != 3'd0) ? CntW'(1) : '0;
        ld_buf = BufW'(pend_q) << (BufW - 8);
        fill_d = 3'd0;
        pend_d = 8'd0;
      end
      default: begin
        ld_cnt = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Byte emitter and output register
  // --------------------------------------------------------------------------
  logic [BufW-1:0] buf_q;
  logic [CntW-1:0] cnt_q;
  logic            m_valid_q;
  logic [7:0]      m_data_q;
  logic            m_last_q;
  logic            move;

  assign move   = (cnt_q != '0) && (!m_valid_q || m_axis_tready_i);
  assign s1_adv = s1_valid_q && ((cnt_q == '0) || ((cnt_q == CntW'(1)) && move));
  assign s_axis_tready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_op_q    <= OP_FLUSH;
      pend_q     <= 8'd0;
      fill_q     <= 3'd0;
      cnt_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      // Advance the lookup stage
      if (in_acc) begin
        s1_valid_q <= to_s1;
        s1_op_q    <= in_op;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        pend_q <= pend_d;
        fill_q <= fill_d;
      end
      // Emitter count: reload on a new request, else count down
      if (s1_adv) begin
        cnt_q <= ld_cnt;
      end else if (move) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      // Output register
      if (move) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      buf_q <= ld_buf;
    end else if (move) begin
      buf_q <= buf_q << 8;
    end
    if (move) begin
      m_data_q <= buf_q[BufW-1 -: 8];
      m_last_q <= (cnt_q == CntW'(1));
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule : huffman_code_bit_packer_unit
